// ===== hdl/handle_table_allocator_assert.svh =====
// Assertion macros for the handle table allocator RTL.
`ifndef HANDLE_TABLE_ALLOCATOR_ASSERT_SVH
`define HANDLE_TABLE_ALLOCATOR_ASSERT_SVH

// Check a property on every rising edge outside of reset.
`define HTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define HTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/hta_pkg.sv =====
// Shared types and constants of the handle table allocator.
`default_nettype none
package hta_pkg;

  localparam int unsigned HANDLE_W     = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned HANDLE_LIMIT = 256;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;     // capture the input item
    logic dispatch;  // clear the result, arm the scan
    logic scan_run;  // issue the next scan read, register the previous one
    logic get_rd;    // read the slot at the captured handle
    logic get_cap;   // capture the read value as result
    logic commit;    // take the scan hit; store the value for add
    logic remove;    // free the slot at the captured handle
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_e  op;
    logic value_zero;
    logic handle_ok;
    logic hit;
    logic last;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/hta_in_if.sv =====
// Input channel of the handle table allocator.
`default_nettype none
interface hta_in_if;
  logic                                valid;
  logic                                ready;
  logic [hta_pkg::OP_W-1:0]            op;
  logic [hta_pkg::HANDLE_W-1:0]        handle;
  logic signed [hta_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output op, output handle, output value, input ready);
  modport sink   (input valid, input op, input handle, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/hta_out_if.sv =====
// Result channel of the handle table allocator.
`default_nettype none
interface hta_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [hta_pkg::HANDLE_W-1:0]        handle_out;
  logic signed [hta_pkg::VALUE_W-1:0]  value_out;

  modport source (output valid, output ok, output handle_out, output value_out, input ready);
  modport sink   (input valid, input ok, input handle_out, input value_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/hta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hta_ctrl.sv =====
// Controller state machine of the handle table allocator.
`default_nettype none
`include "handle_table_allocator_assert.svh"
module hta_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire hta_pkg::status_t st_i,
  output hta_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    GET_RD,
    GET_CAP,
    REMOVE,
    SCAN,
    FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = DISPATCH;
        end
      end
      DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        case (st_i.op)
          hta_pkg::OP_ADD, hta_pkg::OP_FIND: state_d = st_i.value_zero ? FINISH : SCAN;
          hta_pkg::OP_GET:                   state_d = st_i.handle_ok ? GET_RD : FINISH;
          hta_pkg::OP_REMOVE:                state_d = st_i.handle_ok ? REMOVE : FINISH;
          default:                           state_d = FINISH;
        endcase
      end
      GET_RD: begin
        cmd_o.get_rd = 1'b1;
        state_d      = GET_CAP;
      end
      GET_CAP: begin
        cmd_o.get_cap = 1'b1;
        state_d       = FINISH;
      end
      REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = FINISH;
      end
      SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = FINISH;
        end else if (st_i.last) begin
          state_d = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `HTA_ASSERT(a_load_into_free, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result loaded over a pending one")
  `HTA_ASSERT(a_accept_dispatch, (in_valid_i && in_ready_o) |=> (state_q == DISPATCH), "accepted item not dispatched")
  `HTA_ASSERT(a_hit_finishes, (state_q == SCAN && st_i.hit) |=> (state_q == FINISH), "scan hit did not end the scan")

endmodule
`default_nettype wire

// ===== hdl/hta_datapath.sv =====
// Datapath of the handle table allocator: slot memory, scan counter and result registers.
`default_nettype none
module hta_datapath #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hta_pkg::cmd_t                       cmd_i,
  output hta_pkg::status_t                         st_o,
  input  wire logic [hta_pkg::OP_W-1:0]            op_i,
  input  wire logic [hta_pkg::HANDLE_W-1:0]        handle_i,
  input  wire logic signed [hta_pkg::VALUE_W-1:0]  value_i,
  output logic                                     ok_o,
  output logic [hta_pkg::HANDLE_W-1:0]             handle_out_o,
  output logic signed [hta_pkg::VALUE_W-1:0]       value_out_o
);

  // Handles are 8 bits wide, so only this many slots are ever reached.
  localparam int unsigned USED = (SLOT_COUNT < hta_pkg::HANDLE_LIMIT) ?
                                 SLOT_COUNT : hta_pkg::HANDLE_LIMIT;
  localparam int unsigned AW   = $clog2(USED);
  localparam logic [AW-1:0] LAST_IDX = AW'(USED - 1);

  hta_pkg::op_e                       op_q;
  logic [hta_pkg::HANDLE_W-1:0]       hnd_q;
  logic signed [hta_pkg::VALUE_W-1:0] val_q;

  logic [AW-1:0] scan_q;
  logic          scan_act_q;
  logic          rd_live_q;
  logic [AW-1:0] rd_idx_q;
  logic [USED-1:0] vld_q;
  logic          vld_rd_q;

  logic                               res_ok_q;
  logic [hta_pkg::HANDLE_W-1:0]       res_hnd_q;
  logic signed [hta_pkg::VALUE_W-1:0] res_val_q;
  logic                               out_ok_q;
  logic [hta_pkg::HANDLE_W-1:0]       out_hnd_q;
  logic signed [hta_pkg::VALUE_W-1:0] out_val_q;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               hnd_addr;
  logic [hta_pkg::VALUE_W-1:0] rdata;
  logic [hta_pkg::VALUE_W-1:0] entry;
  logic                        ram_we;
  logic                        match;

  assign hnd_addr = hnd_q[AW-1:0];
  assign rd_en    = (cmd_i.scan_run && scan_act_q) || cmd_i.get_rd;
  assign rd_addr  = cmd_i.get_rd ? hnd_addr : scan_q;
  assign ram_we   = cmd_i.commit && (op_q == hta_pkg::OP_ADD);
  // A slot without its valid bit reads as zero.
  assign entry    = vld_rd_q ? rdata : '0;
  assign match    = (op_q == hta_pkg::OP_ADD) ? !vld_rd_q :
                    (vld_rd_q && (rdata == val_q));

  assign st_o.op         = op_q;
  assign st_o.value_zero = (val_q == '0);
  assign st_o.handle_ok  = (hnd_q != '0) && (32'(hnd_q) < 32'(SLOT_COUNT));
  assign st_o.hit        = rd_live_q && match;
  assign st_o.last       = rd_live_q && (rd_idx_q == LAST_IDX);

  hta_ram #(
    .WIDTH(hta_pkg::VALUE_W),
    .DEPTH(USED)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(rd_idx_q),
    .wdata_i(val_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // Control part: scan sequencing and slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      rd_live_q  <= 1'b0;
      scan_q     <= '0;
      vld_q      <= '0;
    end else begin
      if (cmd_i.dispatch) begin
        scan_q     <= AW'(1);
        scan_act_q <= 1'b1;
        rd_live_q  <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rd_live_q <= scan_act_q;
        if (scan_act_q) begin
          if (scan_q == LAST_IDX) begin
            scan_act_q <= 1'b0;
          end else begin
            scan_q <= scan_q + AW'(1);
          end
        end
      end
      if (ram_we) begin
        vld_q[rd_idx_q] <= 1'b1;
      end
      if (cmd_i.remove) begin
        vld_q[hnd_addr] <= 1'b0;
      end
    end
  end

  // Payload part: captured item, read tags, result and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= hta_pkg::op_e'(op_i);
      hnd_q <= handle_i;
      val_q <= value_i;
    end
    if (cmd_i.scan_run) begin
      rd_idx_q <= scan_q;
    end
    if (rd_en) begin
      vld_rd_q <= vld_q[rd_addr];
    end
    if (cmd_i.dispatch) begin
      res_ok_q  <= 1'b0;
      res_hnd_q <= '0;
      res_val_q <= '0;
    end
    if (cmd_i.commit) begin
      res_ok_q  <= 1'b1;
      res_hnd_q <= hta_pkg::HANDLE_W'(rd_idx_q);
    end
    if (cmd_i.get_cap) begin
      res_ok_q  <= 1'b1;
      res_val_q <= entry;
    end
    if (cmd_i.remove) begin
      res_ok_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_ok_q  <= res_ok_q;
      out_hnd_q <= res_hnd_q;
      out_val_q <= res_val_q;
    end
  end

  assign ok_o         = out_ok_q;
  assign handle_out_o = out_hnd_q;
  assign value_out_o  = out_val_q;

endmodule
`default_nettype wire

// ===== hdl/handle_table_allocator.sv =====
// Top level of the handle table allocator: controller, datapath and channel wiring.
//
// Usage: requests arrive on in_i (op, handle, value) and each gives exactly one
// transfer on out_o (ok, handle_out, value_out), in request order.
// Ops: add stores a nonzero value in the lowest free slot from 1 upward, get
// reads a slot, find returns the lowest slot holding a value, remove frees a slot.
// in_i.ready is high while the controller is idle; one request is in work at a time.
// Each request goes from dispatch to a scan (add, find), a slot read and capture
// (get) or a free (remove), then to finish; a bad handle or a zero value goes
// straight from dispatch to finish. The scan reads one slot per cycle through
// the registered read port of the slot RAM, and this read loop sets how long add
// and find take. A new request can be taken in the cycle after the result is
// loaded into the output register.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block holds its own finished result until out_o
// is free, so a stalled receiver stalls the block without losing anything.
// Reset (rst_ni low, asynchronous) clears the slot valid bits at once, so the
// whole table reads as free right after reset; no clearing pass is needed.
`default_nettype none
module handle_table_allocator #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hta_in_if.sink    in_i,
  hta_out_if.source out_o
);

  hta_pkg::cmd_t    cmd;
  hta_pkg::status_t st;

  // Sequence each request: dispatch, scan or single access, then finish.
  hta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Hold the slot table and compute each result.
  hta_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .op_i        (in_i.op),
    .handle_i    (in_i.handle),
    .value_i     (in_i.value),
    .ok_o        (out_o.ok),
    .handle_out_o(out_o.handle_out),
    .value_out_o (out_o.value_out)
  );

endmodule
`default_nettype wire

// ===== sim/handle_table_allocator_checker.sv =====
`timescale 1ns / 100ps
// Checker for the handle table allocator: mirrors the slot table and compares every result.
module handle_table_allocator_checker #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hta_in_if           req_i,
  hta_out_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import hta_pkg::*;

  localparam int unsigned SCAN_END = (SLOT_COUNT < HANDLE_LIMIT) ? SLOT_COUNT : HANDLE_LIMIT;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [VALUE_W-1:0]  value;
  } slot_reply_t;

  logic [VALUE_W-1:0] slot_mirror [SLOT_COUNT];
  slot_reply_t        reply_q [$];
  int unsigned        mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  function automatic logic handle_in_range(logic [HANDLE_W-1:0] h);
    return (h != '0) && (32'(h) < SLOT_COUNT);
  endfunction

  // Apply one request to the mirrored table and return the reply it must give.
  function automatic slot_reply_t apply_request(op_e op, logic [HANDLE_W-1:0] h,
                                                logic [VALUE_W-1:0] v);
    slot_reply_t r;
    r = '0;
    case (op)
      OP_ADD: begin
        if (v != '0) begin
          for (int unsigned i = 1; i < SCAN_END; i++) begin
            if (slot_mirror[i] == '0) begin
              slot_mirror[i] = v;
              r.ok = 1'b1;
              r.handle = HANDLE_W'(i);
              break;
            end
          end
        end
      end
      OP_GET: begin
        if (handle_in_range(h)) begin
          r.ok = 1'b1;
          r.value = slot_mirror[h];
        end
      end
      OP_FIND: begin
        if (v != '0) begin
          for (int unsigned i = 1; i < SCAN_END; i++) begin
            if (slot_mirror[i] == v) begin
              r.ok = 1'b1;
              r.handle = HANDLE_W'(i);
              break;
            end
          end
        end
      end
      default: begin
        if (handle_in_range(h)) begin
          slot_mirror[h] = '0;
          r.ok = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_reply_t want;
    if (!rst_ni) begin
      foreach (slot_mirror[i]) slot_mirror[i] = '0;
      reply_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with none pending",
                          {rsp_i.ok, rsp_i.handle_out, rsp_i.value_out}, '0);
        end else begin
          want = reply_q.pop_front();
          if (rsp_i.ok !== want.ok)
            report_mismatch("ok", rsp_i.ok, want.ok);
          if (rsp_i.handle_out !== want.handle)
            report_mismatch("handle_out", rsp_i.handle_out, want.handle);
          if (rsp_i.value_out !== want.value)
            report_mismatch("value_out", rsp_i.value_out, want.value);
        end
      end
      if (req_i.valid && req_i.ready)
        reply_q.push_back(apply_request(op_e'(req_i.op), req_i.handle, req_i.value));
      pending_o <= reply_q.size();
    end
  end

endmodule

// ===== sim/handle_table_allocator_test.sv =====
`timescale 1ns / 100ps
// Testbench top of the handle table allocator: clock, reset, request stimulus and verdict.
module handle_table_allocator_test;
  import hta_pkg::*;

  // A full-table add scans every slot and the receiver may stall on top of
  // that, so allow a generous quiet stretch before giving up.
  localparam int unsigned IDLE_LIMIT  = 4000;
  // Hold this long after the last result to catch any stray transfer.
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned CHUNK_ITEMS = 85;
  localparam int unsigned CHUNKS      = 10;
  localparam int unsigned POOL_SIZE   = 24;

  typedef enum logic [1:0] {
    MIX_TRAFFIC,
    FILL_TABLE,
    DRAIN_TABLE
  } traffic_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  // Rough count of live slots; the table fills from the bottom, so get and
  // remove mostly aim below it.
  int unsigned live_hint = 1;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  hta_in_if  req_if ();
  hta_out_if rsp_if ();

  handle_table_allocator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  handle_table_allocator_checker table_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none at all while no_idle is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Aim mostly at live slots; keep some reserved-slot and full-range handles.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 14) return HANDLE_W'($urandom_range(0, 255));
    return HANDLE_W'($urandom_range(1, live_hint));
  endfunction

  // Draw from a small pool so duplicates and find hits are common.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 75) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Drive one request, hold it until the transfer, then idle for a gap.
  // With a zero gap valid stays high into the next request.
  task automatic send_request(op_e op, logic [HANDLE_W-1:0] h, logic [VALUE_W-1:0] v);
    int unsigned gap;
    req_if.valid  <= 1'b1;
    req_if.op     <= op;
    req_if.handle <= h;
    req_if.value  <= v;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(traffic_mode_e mode);
    int unsigned         r;
    op_e                 op;
    logic [HANDLE_W-1:0] h;
    logic [VALUE_W-1:0]  v;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_TABLE: begin
        op = (r < 92) ? OP_ADD : (r < 96) ? OP_GET : OP_FIND;
      end
      DRAIN_TABLE: begin
        op = (r < 60) ? OP_REMOVE : (r < 75) ? OP_GET : (r < 90) ? OP_FIND : OP_ADD;
      end
      default: begin
        op = (r < 35) ? OP_ADD : (r < 60) ? OP_GET : (r < 80) ? OP_FIND : OP_REMOVE;
      end
    endcase
    // Unused fields carry random junk as noise.
    h = pick_handle();
    v = pick_value();
    if (op == OP_ADD && v != '0 && live_hint < 255) live_hint++;
    if (op == OP_REMOVE && live_hint > 1) live_hint--;
    send_request(op, h, v);
  endtask

  // Result side: open for a random run, then stall; never stall while no_idle.
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    rsp_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 12);
      rsp_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    req_if.valid  <= 1'b0;
    req_if.op     <= OP_ADD;
    req_if.handle <= '0;
    req_if.value  <= '0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'hffff_ffff;
    value_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad handles, empty-table lookups, zero values, extremes,
    // duplicates, reuse of the lowest free slot.
    send_request(OP_GET,    8'd0,   32'h1234_5678);  // reserved slot
    send_request(OP_REMOVE, 8'd0,   32'h0);          // reserved slot
    send_request(OP_GET,    8'd255, 32'h0);          // top slot, still free
    send_request(OP_FIND,   8'd0,   32'h0000_0005);  // empty table, not found
    send_request(OP_ADD,    8'd0,   32'h0);          // zero value rejected
    send_request(OP_FIND,   8'd0,   32'h0);          // find of zero misses
    send_request(OP_ADD,    8'd255, 32'h8000_0000);
    send_request(OP_ADD,    8'd0,   32'h7fff_ffff);
    send_request(OP_ADD,    8'd0,   32'hffff_ffff);
    send_request(OP_ADD,    8'd0,   32'h0000_0001);
    send_request(OP_ADD,    8'd0,   32'h7fff_ffff);  // duplicate value
    send_request(OP_FIND,   8'd0,   32'h7fff_ffff);  // lowest holder wins
    send_request(OP_GET,    8'd2,   32'h0);
    send_request(OP_REMOVE, 8'd2,   32'hffff_ffff);
    send_request(OP_REMOVE, 8'd2,   32'h0);          // already free
    send_request(OP_FIND,   8'd0,   32'h7fff_ffff);  // now the duplicate
    send_request(OP_ADD,    8'd0,   32'h1234_5678);  // takes the freed slot
    send_request(OP_GET,    8'd1,   32'h0);
    send_request(OP_GET,    8'd2,   32'h0);
    send_request(OP_REMOVE, 8'd255, 32'h0);          // free top slot
    send_request(OP_FIND,   8'd0,   32'h8000_0000);
    send_request(OP_GET,    8'd3,   32'h0);
    send_request(OP_ADD,    8'haa,  32'h55aa_55aa);
    live_hint = 6;

    // Random: mix, fill the table past full, drain it, mix again.
    for (int unsigned c = 0; c < CHUNKS; c++) begin
      no_idle = (c == 1 || c == 5);
      repeat (CHUNK_ITEMS) begin
        if (c < 2 || c >= 8) send_random(MIX_TRAFFIC);
        else if (c < 6) send_random(FILL_TABLE);
        else send_random(DRAIN_TABLE);
      end
    end
    no_idle = 1'b0;
    req_if.valid <= 1'b0;

    // Drain outstanding results, then hold for stray transfers.
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
